>>> rtl/kda_pkg.sv
// Shared types and constants for the key debounce and auto-repeat unit.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package kda_pkg;

  // Number of keys tracked and the number that fit in the scan and result words.
  localparam int NUM_KEYS   = 6;
  localparam int FIELD_KEYS = 6;
  localparam int TIME_W     = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Reset values of the timing registers, in milliseconds.
  localparam logic [CFG_DATA_W-1:0] RELEASE_MS_RST  = CFG_DATA_W'(30);
  localparam logic [CFG_DATA_W-1:0] INITIAL_MS_RST  = CFG_DATA_W'(200);
  localparam logic [CFG_DATA_W-1:0] REPEAT_MS_RST   = CFG_DATA_W'(30);

  // Configuration register indexes. Index 3 selects nothing and is ignored.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELEASE_DEBOUNCE,
    CFG_INITIAL_DELAY,
    CFG_REPEAT_INTERVAL
  } cfg_reg_t;

  // Per-key state. The fourth code is never entered and behaves as holding.
  typedef enum logic [1:0] {
    KS_RELEASED,
    KS_PRESSED,
    KS_HOLDING
  } key_state_t;

  // One key's record in the state memory.
  typedef struct packed {
    key_state_t              state;
    logic [TIME_W-1:0]       last_down;
    logic [TIME_W-1:0]       last_fire;
  } key_rec_t;

  // One memory row holds the records of all keys.
  typedef key_rec_t [NUM_KEYS-1:0] state_row_t;

  localparam key_rec_t KEY_REC_RST = '{state: KS_RELEASED, last_down: '0, last_fire: '0};

  // Timing thresholds handed to every key lane.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] release_ms;
    logic [CFG_DATA_W-1:0] initial_ms;
    logic [CFG_DATA_W-1:0] repeat_ms;
  } timing_cfg_t;

endpackage

`default_nettype wire

>>> rtl/kda_channels_if.sv
// Valid/ready channel interfaces for the scan words and the result words.
// Depends on kda_pkg for the field widths.
`default_nettype none

interface kda_in_if;
  import kda_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [TIME_W-1:0]     now_ms;
  logic [FIELD_KEYS-1:0] pressed_bits;

  modport source (output valid, output now_ms, output pressed_bits, input ready);
  modport sink   (input valid, input now_ms, input pressed_bits, output ready);
endinterface

interface kda_out_if;
  import kda_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FIELD_KEYS-1:0] action_bits;
  logic [FIELD_KEYS-1:0] holding_bits;

  modport source (output valid, output action_bits, output holding_bits, input ready);
  modport sink   (input valid, input action_bits, input holding_bits, output ready);
endinterface

`default_nettype wire

>>> rtl/kda_key_lane.sv
// Next-state logic for one key: debounce, first fire, delay and repeat timing.
// Depends on kda_pkg for the key record and timing types.
`default_nettype none

module kda_key_lane (
  input  kda_pkg::key_rec_t           cur,
  input  logic                        down,
  input  logic [kda_pkg::TIME_W-1:0]  now_ms,
  input  kda_pkg::timing_cfg_t        cfg,
  output kda_pkg::key_rec_t           nxt,
  output logic                        fired,
  output logic                        holding
);
  import kda_pkg::*;

  logic [TIME_W-1:0] since_fire;
  logic [TIME_W-1:0] since_down;
  logic              init_due;
  logic              repeat_due;
  logic              release_due;

  // Elapsed times wrap modulo 2^32, as the timestamp does.
  assign since_fire  = now_ms - cur.last_fire;
  assign since_down  = now_ms - cur.last_down;
  assign init_due    = since_fire > TIME_W'(cfg.initial_ms);
  assign repeat_due  = since_fire > TIME_W'(cfg.repeat_ms);
  assign release_due = since_down > TIME_W'(cfg.release_ms);

  // A down key refreshes its down time and may fire; an up key may release.
  always_comb begin
    nxt   = cur;
    fired = 1'b0;
    if (down) begin
      nxt.last_down = now_ms;
      case (cur.state)
        KS_RELEASED: begin
          nxt.state = KS_PRESSED;
          fired     = 1'b1;
        end
        KS_PRESSED: begin
          if (init_due) begin
            nxt.state = KS_HOLDING;
            fired     = 1'b1;
          end
        end
        default: begin
          nxt.state = KS_HOLDING;
          fired     = repeat_due;
        end
      endcase
      if (fired) begin
        nxt.last_fire = now_ms;
      end
    end else if (release_due) begin
      nxt.state = KS_RELEASED;
    end
  end

  // Holding and the unused fourth code both have the upper state bit set.
  assign holding = nxt.state[1];

endmodule

`default_nettype wire

>>> rtl/kda_key_debounce_core.sv
// Array of key lanes that turns one state row and one scan into the next row.
// Depends on kda_pkg and kda_key_lane.
`default_nettype none

module kda_key_debounce_core (
  input  kda_pkg::state_row_t                cur_row,
  input  logic [kda_pkg::FIELD_KEYS-1:0]     pressed_bits,
  input  logic [kda_pkg::TIME_W-1:0]         now_ms,
  input  kda_pkg::timing_cfg_t               cfg,
  output kda_pkg::state_row_t                nxt_row,
  output logic [kda_pkg::FIELD_KEYS-1:0]     action_bits,
  output logic [kda_pkg::FIELD_KEYS-1:0]     holding_bits
);
  import kda_pkg::*;

  logic [NUM_KEYS-1:0] key_down;
  logic [NUM_KEYS-1:0] key_fired;
  logic [NUM_KEYS-1:0] key_hold;

  // One lane per key; keys beyond the scan word always read up.
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    if (k < FIELD_KEYS) begin : g_in
      assign key_down[k] = pressed_bits[k];
    end else begin : g_up
      assign key_down[k] = 1'b0;
    end

    kda_key_lane u_lane (
      .cur     (cur_row[k]),
      .down    (key_down[k]),
      .now_ms  (now_ms),
      .cfg     (cfg),
      .nxt     (nxt_row[k]),
      .fired   (key_fired[k]),
      .holding (key_hold[k])
    );
  end

  // Only keys that have a place in the result word are reported.
  for (genvar f = 0; f < FIELD_KEYS; f++) begin : g_field
    if (f < NUM_KEYS) begin : g_key
      assign action_bits[f]  = key_fired[f];
      assign holding_bits[f] = key_hold[f];
    end else begin : g_none
      assign action_bits[f]  = 1'b0;
      assign holding_bits[f] = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/key_debounce_autorepeat_unit.sv
// Key debounce and auto-repeat unit. Each scan word (timestamp, one down bit per key) yields
// one result word (fired keys, holding keys). The unit takes one scan word per cycle while
// the input is not stalled. The key state row is read from the state memory at the edge that
// accepts the scan word. All keys are then updated in parallel in the update stage; when that
// stage retires, the row is written back and the result word is registered in the output
// register, from which it is taken when out_if.ready is high.
// A write in the cycle of the next read is forwarded, so scans can follow back to back.
// The result sits in an output register, so a stalled result only blocks the input once the
// update stage is also occupied. The state row carries a valid flag and reads as all keys
// released with zero times until its first write; no clearing pass is needed.
// Depends on kda_pkg, kda_channels_if and kda_key_debounce_core.
`default_nettype none

module key_debounce_autorepeat_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  kda_in_if.sink                            in_if,
  kda_out_if.source                         out_if,
  input  logic                              cfg_we,
  input  logic [kda_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [kda_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import kda_pkg::*;

  timing_cfg_t           cfg_r;
  state_row_t            state_mem [1];
  state_row_t            rd_row_r;
  state_row_t            wr_row_r;
  state_row_t            cur_row;
  state_row_t            nxt_row;
  logic                  row_vld_r;
  logic                  rd_vld_r;
  logic                  fwd_r;
  logic                  s1_v_r;
  logic [TIME_W-1:0]     s1_now_r;
  logic [FIELD_KEYS-1:0] s1_down_r;
  logic                  out_v_r;
  logic [FIELD_KEYS-1:0] out_action_r;
  logic [FIELD_KEYS-1:0] out_hold_r;
  logic [FIELD_KEYS-1:0] action_nxt;
  logic [FIELD_KEYS-1:0] hold_nxt;
  logic                  acc_in;
  logic                  out_free;
  logic                  s1_go;

  // Timing registers; writes to an unused index fall through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.release_ms <= RELEASE_MS_RST;
      cfg_r.initial_ms <= INITIAL_MS_RST;
      cfg_r.repeat_ms  <= REPEAT_MS_RST;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_RELEASE_DEBOUNCE) begin
        cfg_r.release_ms <= cfg_wdata;
      end
      if (cfg_idx == CFG_INITIAL_DELAY) begin
        cfg_r.initial_ms <= cfg_wdata;
      end
      if (cfg_idx == CFG_REPEAT_INTERVAL) begin
        cfg_r.repeat_ms <= cfg_wdata;
      end
    end
  end

  // Handshake: the update stage moves on whenever the output register can take a word.
  assign out_free    = !out_v_r || out_if.ready;
  assign s1_go       = s1_v_r && out_free;
  assign in_if.ready = !s1_v_r || out_free;
  assign acc_in      = in_if.valid && in_if.ready;

  // State memory: read on acceptance, written back when the update stage retires.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      state_mem[0] <= nxt_row;
      wr_row_r     <= nxt_row;
    end
    if (acc_in) begin
      rd_row_r <= state_mem[0];
    end
  end

  // Control: stage valid, row valid flag and the forwarding select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      row_vld_r <= 1'b0;
      rd_vld_r  <= 1'b0;
      fwd_r     <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      s1_v_r  <= acc_in || (s1_v_r && !s1_go);
      out_v_r <= s1_go || (out_v_r && !out_if.ready);
      if (s1_go) begin
        row_vld_r <= 1'b1;
      end
      if (acc_in) begin
        rd_vld_r <= row_vld_r;
        fwd_r    <= s1_go;
      end
    end
  end

  // Scan word held in the update stage.
  always_ff @(posedge clk) begin
    if (acc_in) begin
      s1_now_r  <= in_if.now_ms;
      s1_down_r <= in_if.pressed_bits;
    end
  end

  // A write in the same cycle as the read is not in the read data; take it from the bypass.
  always_comb begin
    if (fwd_r) begin
      cur_row = wr_row_r;
    end else if (rd_vld_r) begin
      cur_row = rd_row_r;
    end else begin
      cur_row = {NUM_KEYS{KEY_REC_RST}};
    end
  end

  kda_key_debounce_core u_core (
    .cur_row      (cur_row),
    .pressed_bits (s1_down_r),
    .now_ms       (s1_now_r),
    .cfg          (cfg_r),
    .nxt_row      (nxt_row),
    .action_bits  (action_nxt),
    .holding_bits (hold_nxt)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_action_r <= action_nxt;
      out_hold_r   <= hold_nxt;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.action_bits  = out_action_r;
  assign out_if.holding_bits = out_hold_r;

  // Forwarding is only selected when the row has been written at least once.
  a_fwd_implies_row: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && fwd_r |-> row_vld_r)
    else $error("forwarding selected before the state row was written");

  // A new scan word never overwrites one that has not retired.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && s1_v_r |-> s1_go)
    else $error("update stage overwritten while occupied");

  // A stalled update stage keeps its scan word.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !out_free |=> s1_v_r && $stable(s1_now_r) && $stable(s1_down_r))
    else $error("update stage lost its word during a stall");

  // Every retired word lands in the output register.
  a_retire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_v_r)
    else $error("retired word did not reach the output register");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for key_debounce_autorepeat_unit: directed and random scan words,
// a bit-accurate predictor of the key state machines, and a result word scoreboard.
// Depends on kda_pkg and the kda_in_if / kda_out_if channel interfaces from the RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kda_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic [CFG_DATA_W-1:0] CFG_MAX = '1;

  typedef struct packed {
    logic [FIELD_KEYS-1:0] action_bits;
    logic [FIELD_KEYS-1:0] holding_bits;
  } result_word_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_BURSTY} rx_mode_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  kda_in_if in_ch ();
  kda_out_if out_ch ();

  key_debounce_autorepeat_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: timing registers and one record per key.
  logic [CFG_DATA_W-1:0] cur_release_ms;
  logic [CFG_DATA_W-1:0] cur_initial_ms;
  logic [CFG_DATA_W-1:0] cur_repeat_ms;
  key_state_t            mdl_state [NUM_KEYS];
  logic [TIME_W-1:0]     mdl_last_down [NUM_KEYS];
  logic [TIME_W-1:0]     mdl_last_fire [NUM_KEYS];

  result_word_t          pending_results [$];
  int                    err_count;
  int                    burst_left;
  bit                    sender_gaps_on;
  logic [TIME_W-1:0]     scan_clock_ms;
  logic [FIELD_KEYS-1:0] held_keys;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advances every key by one scan word and returns the result word it should produce.
  function automatic result_word_t predict_scan(input logic [TIME_W-1:0] now,
                                                input logic [FIELD_KEYS-1:0] down_bits);
    result_word_t res;
    logic [TIME_W-1:0] since_fire;
    logic [TIME_W-1:0] since_down;
    logic fired;
    res = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      since_fire = now - mdl_last_fire[k];
      since_down = now - mdl_last_down[k];
      fired = 1'b0;
      if (down_bits[k]) begin
        mdl_last_down[k] = now;
        case (mdl_state[k])
          KS_RELEASED: begin
            mdl_state[k] = KS_PRESSED;
            fired = 1'b1;
          end
          KS_PRESSED: begin
            if (since_fire > TIME_W'(cur_initial_ms)) begin
              mdl_state[k] = KS_HOLDING;
              fired = 1'b1;
            end
          end
          default: begin
            mdl_state[k] = KS_HOLDING;
            fired = since_fire > TIME_W'(cur_repeat_ms);
          end
        endcase
        if (fired) mdl_last_fire[k] = now;
      end else if (since_down > TIME_W'(cur_release_ms)) begin
        mdl_state[k] = KS_RELEASED;
      end
      res.action_bits[k]  = fired;
      res.holding_bits[k] = (mdl_state[k] != KS_RELEASED) && (mdl_state[k] != KS_PRESSED);
    end
    return res;
  endfunction

  // Every scan word taken by the unit gets its expected result queued.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      pending_results.push_back(predict_scan(in_ch.now_ms, in_ch.pressed_bits));
    end
  end

  // Compare each result word with the oldest expectation.
  always @(posedge clk) begin
    result_word_t exp_word;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result word, expected none actual %h/%h", $realtime,
                 out_ch.action_bits, out_ch.holding_bits);
      end else begin
        exp_word = pending_results.pop_front();
        if (out_ch.action_bits !== exp_word.action_bits) begin
          err_count++;
          $display("%0t: action_bits mismatch, expected %h actual %h", $realtime,
                   exp_word.action_bits, out_ch.action_bits);
        end
        if (out_ch.holding_bits !== exp_word.holding_bits) begin
          err_count++;
          $display("%0t: holding_bits mismatch, expected %h actual %h", $realtime,
                   exp_word.holding_bits, out_ch.holding_bits);
        end
      end
    end
  end

  // Result side backpressure in one of four stall styles, redrawn at random during the run.
  initial begin
    rx_mode_t rx_mode;
    int unsigned rx_tick;
    logic [7:0] rx_pattern;
    rx_mode = RX_ALWAYS;
    rx_tick = 0;
    rx_pattern = 8'b1011_0110;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (rx_tick % 64 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_ALWAYS: out_ch.ready = 1'b1;
        RX_RANDOM: out_ch.ready = ($urandom_range(0, 3) != 0);
        RX_PATTERN: begin
          out_ch.ready = rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
        end
        default: out_ch.ready = (rx_tick % 16 >= 6);
      endcase
    end
  end

  // Watchdog: ends the run when neither channel moves a word for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
    $display("[key_debounce_autorepeat_unit] ERROR");
    $finish;
  end

  // Sends one scan word; called and returns at a falling edge. Gaps fall between bursts.
  task automatic send_scan(input logic [TIME_W-1:0] now, input logic [FIELD_KEYS-1:0] keys);
    int gap;
    if (burst_left == 0) begin
      gap = sender_gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.now_ms = now;
    in_ch.pressed_bits = keys;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    scan_clock_ms = now;
  endtask

  // Holds the input until every expected result word has come back.
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Register write; the unit must be idle. The predictor copy follows the write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_RELEASE_DEBOUNCE: cur_release_ms = value;
      CFG_INITIAL_DELAY:    cur_initial_ms = value;
      CFG_REPEAT_INTERVAL:  cur_repeat_ms = value;
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [CFG_DATA_W-1:0] rel, input logic [CFG_DATA_W-1:0] ini,
                            input logic [CFG_DATA_W-1:0] rep);
    drain_results();
    write_reg(CFG_RELEASE_DEBOUNCE, rel);
    write_reg(CFG_INITIAL_DELAY, ini);
    write_reg(CFG_REPEAT_INTERVAL, rep);
  endtask

  // Reset timing: press, initial delay edge, repeat edge, release debounce edge.
  task automatic test_typematic_defaults();
    send_scan(32'd1000, 6'h01);
    send_scan(32'd1200, 6'h01);
    send_scan(32'd1201, 6'h01);
    send_scan(32'd1231, 6'h01);
    send_scan(32'd1232, 6'h01);
    send_scan(32'd1262, 6'h00);
    send_scan(32'd1263, 6'h00);
    send_scan(32'd2000, 6'h3F);
    send_scan(32'd2040, 6'h00);
  endtask

  // A write to the unused index must leave the initial delay at its reset value.
  task automatic test_unused_register_index();
    drain_results();
    write_reg(CFG_UNUSED_IDX, '0);
    send_scan(32'd3000, 6'h04);
    send_scan(32'd3150, 6'h04);
    send_scan(32'd3201, 6'h04);
  endtask

  // Zero delays fire whenever the timestamp moves; timestamps wrap through zero.
  task automatic test_zero_delays_and_wrap();
    set_timing('0, '0, '0);
    send_scan(32'hFFFF_FFFF, 6'h3F);
    send_scan(32'hFFFF_FFFF, 6'h3F);
    send_scan(32'h0000_0000, 6'h3F);
    send_scan(32'h0000_0000, 6'h00);
    send_scan(32'h0000_0001, 6'h00);
    send_scan(32'h0000_0002, 6'h2A);
    send_scan(32'h0000_0003, 6'h15);
  endtask

  // Largest delays: the strict comparisons sit right at 65535 ms.
  task automatic test_max_delays();
    logic [TIME_W-1:0] t0;
    t0 = 32'h0010_0000;
    set_timing(CFG_MAX, CFG_MAX, CFG_MAX);
    send_scan(t0, 6'h00);
    send_scan(t0 + 32'd1, 6'h01);
    send_scan(t0 + 32'd65536, 6'h01);
    send_scan(t0 + 32'd65537, 6'h01);
    send_scan(t0 + 32'd131072, 6'h00);
    send_scan(t0 + 32'd131073, 6'h00);
  endtask

  // Random scans: keys held over stretches, time steps aimed at the timing thresholds,
  // plus some noise words with arbitrary keys and timestamps.
  task automatic run_scans(input int count, input bit pause_midway);
    logic [TIME_W-1:0] step;
    logic [TIME_W-1:0] next_ms;
    logic [FIELD_KEYS-1:0] flips;
    logic [CFG_DATA_W-1:0] edge_ms;
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) drain_results();
      if ($urandom_range(0, 7) == 0) begin
        next_ms = ($urandom_range(0, 1) == 0) ? $urandom() : scan_clock_ms + $urandom_range(0, 40);
        send_scan(next_ms, FIELD_KEYS'($urandom()));
      end else begin
        for (int k = 0; k < FIELD_KEYS; k++) flips[k] = ($urandom_range(0, 5) == 0);
        held_keys ^= flips;
        case ($urandom_range(0, 2))
          0: edge_ms = cur_release_ms;
          1: edge_ms = cur_initial_ms;
          default: edge_ms = cur_repeat_ms;
        endcase
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5: step = $urandom_range(0, 3);
          6, 7, 8, 9, 10, 11: step = TIME_W'(edge_ms) + $urandom_range(0, 2) - 32'd1;
          19: step = $urandom();
          default: step = $urandom_range(0, 2 * int'(edge_ms) + 2);
        endcase
        send_scan(scan_clock_ms + step, held_keys);
      end
    end
  endtask

  // Several timing settings, with and without idle gaps on the input.
  task automatic test_random_traffic();
    held_keys = '0;
    set_timing(16'd30, 16'd200, 16'd30);
    run_scans(80, 1'b0);
    set_timing(16'd5, 16'd20, 16'd3);
    run_scans(80, 1'b1);
    sender_gaps_on = 1'b0;
    set_timing('0, '0, '0);
    run_scans(60, 1'b0);
    sender_gaps_on = 1'b1;
    set_timing(CFG_MAX, CFG_MAX, CFG_MAX);
    run_scans(60, 1'b0);
    set_timing(CFG_DATA_W'($urandom_range(0, 300)), CFG_DATA_W'($urandom_range(0, 300)),
               CFG_DATA_W'($urandom_range(0, 300)));
    run_scans(120, 1'b1);
  endtask

  // Test sequence.
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.now_ms = '0;
    in_ch.pressed_bits = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    err_count = 0;
    burst_left = 0;
    sender_gaps_on = 1'b1;
    scan_clock_ms = '0;
    held_keys = '0;
    cur_release_ms = RELEASE_MS_RST;
    cur_initial_ms = INITIAL_MS_RST;
    cur_repeat_ms = REPEAT_MS_RST;
    for (int k = 0; k < NUM_KEYS; k++) begin
      mdl_state[k] = KS_RELEASED;
      mdl_last_down[k] = '0;
      mdl_last_fire[k] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_typematic_defaults();
    test_unused_register_index();
    test_zero_delays_and_wrap();
    test_max_delays();
    test_random_traffic();

    drain_results();
    repeat (8) @(negedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("[key_debounce_autorepeat_unit] OK");
    end else begin
      $display("[key_debounce_autorepeat_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
